// ===== src/lir_pkg.sv =====
// Package: shared types, constants and register codes of the resampler.
`timescale 1ns / 1ps

package lir_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int SAMPLE_W       = 16;
  localparam int FRAC_W         = 32;
  localparam int STEP_W         = 36;
  localparam int FRAMES_W       = 24;
  localparam int OUT_W          = 32;
  localparam int CFG_DATA_W     = 36;
  localparam int CFG_INDEX_W    = 2;
  localparam int MAX_RESULTS    = 64;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 36'd2863311530;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_TOTAL_FRAMES = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_final;
  } item_t;

  // Queue read side as seen by the engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INTERP,
    ST_EMIT,
    ST_FINISH,
    ST_PAD
  } state_t;

endpackage

// ===== src/linear_interp_resampler.sv =====
// Each interpolated result passes through the shared multiplier (registered into step_r), then
// the output register; each padding result goes straight to the output register. A sample is
// loaded from the queue and started; interpolation closes with a finish step, and padding
// follows a final sample.
// The two-entry queue keeps accepting while it has room, also while the back end works or the output stalls.
// Reset (rst, synchronous) clears state, queue and the output valid flag, and restores register defaults.
`timescale 1ns / 1ps

module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] pcm_sample,
  input  logic                       final_sample,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic signed [OUT_W-1:0]    stereo_sample,
  output logic                       run_last,
  output logic                       sound_done,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic [STEP_W-1:0]   phase_step;
  logic [FRAMES_W-1:0] total_frames;
  queue_head_t         head;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= PHASE_STEP_RESET;
      total_frames <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step   <= cfg_data[STEP_W-1:0];
        REG_TOTAL_FRAMES: total_frames <= cfg_data[FRAMES_W-1:0];
        default:          ;
      endcase
    end
  end

  lir_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pcm_sample   (pcm_sample),
    .final_sample (final_sample),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .head         (head),
    .pop          (pop)
  );

  lir_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .phase_step    (phase_step),
    .total_frames  (total_frames),
    .stereo_sample (stereo_sample),
    .run_last      (run_last),
    .sound_done    (sound_done),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule

// ===== src/lir_front.sv =====
// Front end: accepts input transactions into a two-entry queue.
`timescale 1ns / 1ps

module lir_front
  import lir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] pcm_sample,
  input  logic                       final_sample,
  input  logic                       in_valid,
  output logic                       in_stall,
  output queue_head_t                head,
  input  logic                       pop
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              do_pop;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].sample   <= pcm_sample;
      mem[wr_ptr].is_final <= final_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lir_back.sv =====
// Back end: interpolation and padding sequencer with the output register.
`timescale 1ns / 1ps

module lir_back
  import lir_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  queue_head_t              head,
  output logic                     pop,
  input  logic [STEP_W-1:0]        phase_step,
  input  logic [FRAMES_W-1:0]      total_frames,
  output logic signed [OUT_W-1:0]  stereo_sample,
  output logic                     run_last,
  output logic                     sound_done,
  output logic                     out_valid,
  input  logic                     out_stall
);

  localparam int PW    = COUNT_BITS + FRAC_W;
  localparam int CMP_W = (COUNT_BITS > FRAMES_W) ? COUNT_BITS : FRAMES_W;
  localparam int N_W   = $clog2(MAX_RESULTS + 1);
  localparam int PROD_W = SAMPLE_W + 1 + FRAC_W + 1;

  state_t state, state_next;

  logic signed [SAMPLE_W-1:0] cur;
  logic                       is_fin;
  logic signed [SAMPLE_W-1:0] prev;
  logic                       have;
  logic [COUNT_BITS-1:0]      idx;
  logic [PW-1:0]              phase;
  logic [COUNT_BITS-1:0]      oc;
  logic [N_W-1:0]             n;
  logic [SAMPLE_W-1:0]        step_r;

  logic signed [SAMPLE_W:0]   delta;
  logic signed [PROD_W-1:0]   prod;
  logic [PW-1:0]              phase_nx;
  logic [COUNT_BITS-1:0]      oc_inc;
  logic                       cnt_ok, oc_ok, match;
  logic                       n_ok_next, oc_inc_ok, match_nx;
  logic                       slot_free, go_interp, go_pad;

  // control strobes
  logic ld_item, init_first, ld_step, emit_interp, emit_pad, finish, clear;

  assign delta    = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
  assign prod     = delta * $signed({1'b0, phase[FRAC_W-1:0]});
  assign phase_nx = phase + PW'(phase_step);
  assign oc_inc   = oc + 1'b1;

  assign cnt_ok    = n < N_W'(MAX_RESULTS);
  assign n_ok_next = n < N_W'(MAX_RESULTS - 1);
  assign oc_ok     = CMP_W'(oc) < CMP_W'(total_frames);
  assign oc_inc_ok = CMP_W'(oc_inc) < CMP_W'(total_frames);
  assign match     = phase[PW-1:FRAC_W] == idx;
  assign match_nx  = phase_nx[PW-1:FRAC_W] == idx;

  assign slot_free = !out_valid || !out_stall;
  assign go_interp = cnt_ok && oc_ok && match;
  assign go_pad    = cnt_ok && oc_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (head.valid) state_next = ST_START;
      ST_START:  begin
        if (have)        state_next = ST_INTERP;
        else if (is_fin) state_next = ST_PAD;
        else             state_next = ST_IDLE;
      end
      ST_INTERP: state_next = go_interp ? ST_EMIT : ST_FINISH;
      ST_EMIT:   if (slot_free) state_next = ST_INTERP;
      ST_FINISH: state_next = is_fin ? ST_PAD : ST_IDLE;
      ST_PAD:    if (!go_pad) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    ld_item     = 1'b0;
    init_first  = 1'b0;
    ld_step     = 1'b0;
    emit_interp = 1'b0;
    emit_pad    = 1'b0;
    finish      = 1'b0;
    clear       = 1'b0;
    unique case (state)
      ST_IDLE:   begin
        pop     = head.valid;
        ld_item = head.valid;
      end
      ST_START:  init_first  = !have;
      ST_INTERP: ld_step     = go_interp;
      ST_EMIT:   emit_interp = slot_free;
      ST_FINISH: finish      = 1'b1;
      ST_PAD:    begin
        emit_pad = go_pad && slot_free;
        clear    = !go_pad;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // item payload and multiplier result
  always_ff @(posedge clk) begin
    if (ld_item) begin
      cur    <= head.item.sample;
      is_fin <= head.item.is_final;
    end
    if (ld_step) step_r <= prod[FRAC_W +: SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prev  <= '0;
      have  <= 1'b0;
      idx   <= '0;
      phase <= '0;
      oc    <= '0;
    end else begin
      if (init_first) begin
        prev <= cur;
        have <= 1'b1;
        idx  <= '0;
      end
      if (finish) begin
        prev <= cur;
        idx  <= idx + 1'b1;
      end
      if (emit_interp) phase <= phase_nx;
      if (emit_interp || emit_pad) oc <= oc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) n <= '0;
    else if (ld_item) n <= '0;
    else if (emit_interp || emit_pad) n <= n + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_interp || emit_pad) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // a run continues while room and frames remain and either the phase still
  // sits on this index or padding follows
  always_ff @(posedge clk) begin
    if (emit_interp) begin
      stereo_sample <= {prev + $signed(step_r), {SAMPLE_W{1'b0}}};
      run_last      <= !(n_ok_next && oc_inc_ok && (match_nx || is_fin));
      sound_done    <= !oc_inc_ok;
    end else if (emit_pad) begin
      stereo_sample <= {cur, {SAMPLE_W{1'b0}}};
      run_last      <= !(n_ok_next && oc_inc_ok);
      sound_done    <= !oc_inc_ok;
    end
  end

endmodule

// ===== src/lir_checker.sv =====
// Checker: port-level properties of the resampler, bound to the top level.
`timescale 1ns / 1ps

module lir_checker
  import lir_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic signed [OUT_W-1:0] stereo_sample,
  input logic                    run_last,
  input logic                    sound_done,
  input logic                    out_valid,
  input logic                    out_stall
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stereo_sample) &&
                               $stable(run_last) && $stable(sound_done))
    else $error("stalled result changed");

  a_scaled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stereo_sample[SAMPLE_W-1:0] == '0)
    else $error("result not scaled by 65536");

  // the frame that reaches the total always closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && sound_done |-> run_last)
    else $error("done result not marked last");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind linear_interp_resampler lir_checker u_chk (.*);
